// File: src/ultrasonic_echo_ranger_macros.svh
// assertion macros shared by the ranger rtl
// each expects clk and arst_n in the scope of the module that uses it
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication
`define UER_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ranger check failed");

// next-cycle implication
`define UER_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ranger check failed");

`endif

// File: src/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

	// counter width default
	localparam int COUNTER_WIDTH_DEF = 16;

	// field widths
	localparam int TRIG_W  = 8;
	localparam int TIME_W  = 16;
	localparam int DIST_W  = 14;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST = 8'd15;
	localparam logic [TIME_W-1:0] MIN_ECHO_RST  = 16'd100;
	localparam logic [TIME_W-1:0] MAX_ECHO_RST  = 16'd29999;
	localparam logic [TIME_W-1:0] TIMEOUT_RST   = 16'd30000;

	// width * 17 / 100 as width * ceil(17 * 2^24 / 100) >> 24, exact for 16-bit widths
	localparam int SPEED_NUM  = 17;
	localparam int SPEED_DEN  = 100;
	localparam int DIST_SHIFT = 24;
	localparam int MULT_W     = 22;
	localparam logic [MULT_W-1:0] DIST_MULT =
		MULT_W'(((SPEED_NUM * (64'd1 << DIST_SHIFT)) + SPEED_DEN - 1) / SPEED_DEN);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIG_WIDTH = 2'd0,
		REG_MIN_ECHO   = 2'd1,
		REG_MAX_ECHO   = 2'd2,
		REG_TIMEOUT    = 2'd3
	} reg_idx_t;

	// measurement phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RISE  = 2'd1,
		PH_FALL  = 2'd2,
		PH_READY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [TRIG_W-1:0] trig_width;
		logic [TIME_W-1:0] min_echo;
		logic [TIME_W-1:0] max_echo;
		logic [TIME_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic echo;
		logic rd;
		logic abrt;
		logic start;
	} req_t;

	typedef struct packed {
		logic read_ok;
		logic done;
		logic accepted;
	} flags_t;

endpackage

// File: src/uer_range.sv
`timescale 1ns / 1ps

module uer_range (
	input  logic                        qualify,
	input  logic [uer_pkg::TIME_W-1:0]  width,
	input  logic [uer_pkg::TIME_W-1:0]  min_echo,
	input  logic [uer_pkg::TIME_W-1:0]  max_echo,
	output logic                        valid,
	output logic [uer_pkg::DIST_W-1:0]  distance
);

	localparam int PROD_W = uer_pkg::TIME_W + uer_pkg::MULT_W;

	logic [PROD_W-1:0] prod;

	// bounds check
	assign valid = qualify && (width >= min_echo) && (width <= max_echo);

	// distance by reciprocal multiply
	assign prod = PROD_W'(width) * PROD_W'(uer_pkg::DIST_MULT);
	assign distance = valid ?
		prod[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W] : '0;

endmodule

// File: src/uer_ctrl.sv
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_macros.svh"

module uer_ctrl #(
	parameter int COUNTER_WIDTH = uer_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  uer_pkg::req_t               req,
	input  uer_pkg::cfg_t               cfg,
	output logic                        trigger,
	output uer_pkg::phase_t             phase,
	output uer_pkg::flags_t             flags,
	output logic                        sample_valid,
	output logic [uer_pkg::TIME_W-1:0]  sample_pulse_us,
	output logic [uer_pkg::DIST_W-1:0]  sample_distance_mm
);

	localparam int EW = (COUNTER_WIDTH > uer_pkg::TIME_W) ? COUNTER_WIDTH : uer_pkg::TIME_W;

	uer_pkg::phase_t phase_q, phase_d;
	logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic echo_prev_q;
	logic trig_q, trig_d;
	logic valid_q;
	logic [uer_pkg::TIME_W-1:0] width_q;
	logic [uer_pkg::DIST_W-1:0] dist_q;
	uer_pkg::flags_t flags_q, flags_d;

	logic rise_edge, fall_edge, tmo;
	logic [EW-1:0] cnt_ext, inc_ext;
	logic [uer_pkg::TIME_W-1:0] cap_width, fin_width;
	logic fin, fin_qual;
	logic rng_valid;
	logic [uer_pkg::DIST_W-1:0] rng_dist;

	// edge and counter helpers
	assign rise_edge = req.echo && !echo_prev_q;
	assign fall_edge = !req.echo && echo_prev_q;
	assign cnt_inc   = (&cnt_q) ? cnt_q : cnt_q + COUNTER_WIDTH'(1);
	assign cnt_ext   = EW'(cnt_q);
	assign inc_ext   = EW'(cnt_inc);
	assign tmo       = inc_ext >= EW'(cfg.timeout);
	assign cap_width = (cnt_ext > EW'({uer_pkg::TIME_W{1'b1}})) ?
		{uer_pkg::TIME_W{1'b1}} : cnt_ext[uer_pkg::TIME_W-1:0];

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (req.start) phase_d = uer_pkg::PH_RISE;
			end
			uer_pkg::PH_READY: begin
				if (req.rd) phase_d = uer_pkg::PH_IDLE;
			end
			uer_pkg::PH_RISE: begin
				if (req.abrt) phase_d = uer_pkg::PH_READY;
				else if (rise_edge) phase_d = uer_pkg::PH_FALL;
				else if (tmo) phase_d = uer_pkg::PH_READY;
			end
			uer_pkg::PH_FALL: begin
				if (req.abrt || fall_edge || tmo) phase_d = uer_pkg::PH_READY;
			end
			default: phase_d = uer_pkg::PH_IDLE;
		endcase
	end

	// counter, trigger and completion actions
	always_comb begin
		cnt_d    = cnt_q;
		trig_d   = trig_q;
		flags_d  = '0;
		fin      = 1'b0;
		fin_qual = 1'b0;
		fin_width = '0;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (req.start) begin
					flags_d.accepted = 1'b1;
					cnt_d  = '0;
					trig_d = 1'b1;
				end
			end
			uer_pkg::PH_READY: begin
				if (req.rd) flags_d.read_ok = 1'b1;
			end
			uer_pkg::PH_RISE, uer_pkg::PH_FALL: begin
				if (req.abrt) begin
					fin = 1'b1;
				end else if (phase_q == uer_pkg::PH_RISE && rise_edge) begin
					cnt_d  = '0;
					trig_d = 1'b0;
				end else if (phase_q == uer_pkg::PH_FALL && fall_edge) begin
					fin       = 1'b1;
					fin_qual  = 1'b1;
					fin_width = cap_width;
				end else if (tmo) begin
					fin = 1'b1;
				end else begin
					cnt_d  = cnt_inc;
					trig_d = (phase_q == uer_pkg::PH_RISE) &&
						(inc_ext < EW'(cfg.trig_width));
				end
				if (fin) begin
					flags_d.done = 1'b1;
					cnt_d  = '0;
					trig_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	uer_range u_range (
		.qualify  (fin_qual),
		.width    (fin_width),
		.min_echo (cfg.min_echo),
		.max_echo (cfg.max_echo),
		.valid    (rng_valid),
		.distance (rng_dist)
	);

	// state update per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uer_pkg::PH_IDLE;
			cnt_q       <= '0;
			echo_prev_q <= 1'b0;
			trig_q      <= 1'b0;
			flags_q     <= '0;
			valid_q     <= 1'b0;
			width_q     <= '0;
			dist_q      <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			echo_prev_q <= req.echo;
			trig_q      <= trig_d;
			flags_q     <= flags_d;
			if (fin) begin
				valid_q <= rng_valid;
				width_q <= fin_width;
				dist_q  <= rng_dist;
			end
		end
	end

	assign trigger            = trig_q;
	assign phase              = phase_q;
	assign flags              = flags_q;
	assign sample_valid       = valid_q;
	assign sample_pulse_us    = width_q;
	assign sample_distance_mm = dist_q;

	// checks
	`UER_ASSERT_IMP(a_trig_only_rise, trig_q, phase_q == uer_pkg::PH_RISE)
	`UER_ASSERT_IMP(a_done_ready, flags_q.done, phase_q == uer_pkg::PH_READY)
	`UER_ASSERT_IMP(a_start_trig, flags_q.accepted, trig_q && phase_q == uer_pkg::PH_RISE)
	`UER_ASSERT_IMP(a_invalid_no_dist, !valid_q, dist_q == '0)
	`UER_ASSERT_NXT(a_hold_on_stall, !accept, $stable(phase_q) && $stable(cnt_q))

endmodule

// File: src/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// Ultrasonic echo-pulse ranger, one input word per microsecond tick.
// Input stream s_axis: each word carries the start, abort and read strobes
// and the sampled echo level. Output stream m_axis: one result word for each
// input word, giving the trigger pin level, the phase, the event flags of the
// tick and the stored sample (valid, pulse width, distance in mm).
// Configuration: cfg_we with cfg_addr selects trigger width, min echo,
// max echo or timeout; write only while the streams are quiet.
// Latency: the result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle while the receiver keeps m_axis_tready high; the
// phase machine, counter and the single distance multiplier all settle between
// the input word and the state registers that drive the result word.
// Stall: the output register holds its word while m_axis_tready is low, and
// s_axis_tready is low only while a word waits and the receiver stalls.
// Reset (arst_n low): phase idle, counter, trigger and stored sample cleared,
// registers back to 15, 100, 29999 and 30000, no output word pending.

module ultrasonic_echo_ranger #(
	parameter int COUNTER_WIDTH = uer_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// start_request, abort_request, read_request, echo_level, zero fill
	input  logic [7:0]                     s_axis_tdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// trigger_level, phase, start_accepted, measurement_done, read_ok,
	// sample_valid, sample_pulse_us, sample_distance_mm, zero fill
	output logic [39:0]                    m_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic                           cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [uer_pkg::TIME_W-1:0]     cfg_wdata
);

	uer_pkg::cfg_t   cfg_q;
	uer_pkg::req_t   req;
	uer_pkg::phase_t phase;
	uer_pkg::flags_t flags;
	logic accept;
	logic out_valid_q;
	logic trigger;
	logic sample_valid;
	logic [uer_pkg::TIME_W-1:0] sample_pulse_us;
	logic [uer_pkg::DIST_W-1:0] sample_distance_mm;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_width <= uer_pkg::TRIG_WIDTH_RST;
			cfg_q.min_echo   <= uer_pkg::MIN_ECHO_RST;
			cfg_q.max_echo   <= uer_pkg::MAX_ECHO_RST;
			cfg_q.timeout    <= uer_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (uer_pkg::reg_idx_t'(cfg_addr))
				uer_pkg::REG_TRIG_WIDTH: cfg_q.trig_width <= cfg_wdata[uer_pkg::TRIG_W-1:0];
				uer_pkg::REG_MIN_ECHO:   cfg_q.min_echo   <= cfg_wdata;
				uer_pkg::REG_MAX_ECHO:   cfg_q.max_echo   <= cfg_wdata;
				uer_pkg::REG_TIMEOUT:    cfg_q.timeout    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = uer_pkg::req_t'(s_axis_tdata[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	uer_ctrl #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.req                (req),
		.cfg                (cfg_q),
		.trigger            (trigger),
		.phase              (phase),
		.flags              (flags),
		.sample_valid       (sample_valid),
		.sample_pulse_us    (sample_pulse_us),
		.sample_distance_mm (sample_distance_mm)
	);

	// result word straight from the state registers
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, sample_distance_mm, sample_pulse_us, sample_valid,
		flags.read_ok, flags.done, flags.accepted, 2'(phase), trigger};

endmodule

// File: sim/ranger_check.sv
`timescale 1ns / 1ps

// watches both streams and the register port, predicts every result word
// of the ranger and compares the words as they leave
module ranger_check
	import uer_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           s_axis_tdata,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [39:0]          m_axis_tdata,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [TIME_W-1:0]    cfg_wdata,
	output int                   errors,
	output int                   pending,
	output int                   words_checked,
	output int                   measurements,
	output int                   valid_samples
);

	// one result word, lowest field in the lowest bits
	typedef struct packed {
		logic [DIST_W-1:0] dist_mm;
		logic [TIME_W-1:0] pulse;
		logic              valid;
		logic              rd_ok;
		logic              done;
		logic              acc;
		phase_t            ph;
		logic              trig;
	} ranger_word_t;

	// predicted state and register copy
	cfg_t              regs;
	phase_t            ph_q;
	logic [TIME_W-1:0] tick_cnt;
	logic              echo_last;
	logic              trig_q;
	logic [TIME_W-1:0] held_width;
	logic [DIST_W-1:0] held_dist;
	logic              held_valid;

	ranger_word_t predicted_samples[$];
	int err_cnt = 0;
	int n_words = 0;
	int n_done = 0;
	int n_valid = 0;

	// store a finished sample and move to result ready
	function automatic void finish_sample(input logic [TIME_W-1:0] w, input logic ok);
		int unsigned mm;
		mm = (int'(w) * SPEED_NUM) / SPEED_DEN;
		held_width = w;
		held_valid = ok;
		held_dist = ok ? mm[DIST_W-1:0] : '0;
		ph_q = PH_READY;
		trig_q = 1'b0;
		tick_cnt = '0;
	endfunction

	// one microsecond tick of the ranger
	function automatic ranger_word_t step_ranger(input req_t r);
		ranger_word_t o;
		phase_t p;
		logic ok;
		p = ph_q;
		o = '0;
		if (p == PH_IDLE) begin
			if (r.start) begin
				o.acc = 1'b1;
				tick_cnt = '0;
				trig_q = 1'b1;
				ph_q = PH_RISE;
			end
		end else if (p == PH_READY) begin
			if (r.rd) begin
				o.rd_ok = 1'b1;
				ph_q = PH_IDLE;
			end
		end else if (r.abrt) begin
			finish_sample('0, 1'b0);
			o.done = 1'b1;
		end else if (p == PH_RISE && r.echo && !echo_last) begin
			tick_cnt = '0;
			trig_q = 1'b0;
			ph_q = PH_FALL;
		end else if (p == PH_FALL && !r.echo && echo_last) begin
			ok = (tick_cnt >= regs.min_echo) && (tick_cnt <= regs.max_echo);
			finish_sample(tick_cnt, ok);
			o.done = 1'b1;
		end else begin
			// counter saturates, timeout checked after the advance
			if (tick_cnt != '1)
				tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= regs.timeout) begin
				finish_sample('0, 1'b0);
				o.done = 1'b1;
			end else begin
				trig_q = (p == PH_RISE) && (tick_cnt < {8'd0, regs.trig_width});
			end
		end
		echo_last = r.echo;
		o.trig = trig_q;
		o.ph = ph_q;
		o.valid = held_valid;
		o.pulse = held_width;
		o.dist_mm = held_dist;
		return o;
	endfunction

	task automatic compare_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// compare leaving words, then predict the word taken this edge
	always @(posedge clk or negedge arst_n) begin
		ranger_word_t got;
		ranger_word_t want;
		if (!arst_n) begin
			regs.trig_width = TRIG_WIDTH_RST;
			regs.min_echo = MIN_ECHO_RST;
			regs.max_echo = MAX_ECHO_RST;
			regs.timeout = TIMEOUT_RST;
			ph_q = PH_IDLE;
			tick_cnt = '0;
			echo_last = 1'b0;
			trig_q = 1'b0;
			held_width = '0;
			held_dist = '0;
			held_valid = 1'b0;
			predicted_samples.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = ranger_word_t'(m_axis_tdata[36:0]);
				if (predicted_samples.size() == 0) begin
					$error("result word 0x%010h with nothing expected", m_axis_tdata);
					err_cnt++;
				end else begin
					want = predicted_samples.pop_front();
					compare_field("trigger_level", want.trig, got.trig);
					compare_field("phase", want.ph, got.ph);
					compare_field("start_accepted", want.acc, got.acc);
					compare_field("measurement_done", want.done, got.done);
					compare_field("read_ok", want.rd_ok, got.rd_ok);
					compare_field("sample_valid", want.valid, got.valid);
					compare_field("sample_pulse_us", want.pulse, got.pulse);
					compare_field("sample_distance_mm", want.dist_mm, got.dist_mm);
					n_words++;
					if (want.done)
						n_done++;
					if (want.done && want.valid)
						n_valid++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_samples.push_back(step_ranger(req_t'(s_axis_tdata[3:0])));
			// register writes take effect for words taken after this edge
			if (cfg_we) begin
				case (cfg_addr)
					REG_TRIG_WIDTH: regs.trig_width = cfg_wdata[TRIG_W-1:0];
					REG_MIN_ECHO:   regs.min_echo = cfg_wdata;
					REG_MAX_ECHO:   regs.max_echo = cfg_wdata;
					REG_TIMEOUT:    regs.timeout = cfg_wdata;
					default: ;
				endcase
			end
		end
		errors <= err_cnt;
		pending <= predicted_samples.size();
		words_checked <= n_words;
		measurements <= n_done;
		valid_samples <= n_valid;
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import uer_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic                 clk;
	logic                 arst_n = 1'b0;
	// start_request, abort_request, read_request, echo_level, zero fill
	logic [7:0]           s_axis_tdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// trigger_level, phase, start_accepted, measurement_done, read_ok,
	// sample_valid, sample_pulse_us, sample_distance_mm, zero fill
	logic [39:0]          m_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = REG_TRIG_WIDTH;
	logic [TIME_W-1:0]    cfg_wdata = '0;

	int errors, pending, words_checked, measurements, valid_samples;

	int items_sent = 0;
	int burst_left = 0;
	int cycle_cnt = 0;
	int cur_trig = 15;
	int cur_min = 100;
	int cur_max = 29999;
	int cur_timeout = 30000;

	// receiver pattern state
	int rx_mode = 0;
	int rx_left = 0;
	int rx_hold = 0;
	bit rx_held = 1'b0;

	ultrasonic_echo_ranger dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	ranger_check mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending),
		.words_checked (words_checked),
		.measurements  (measurements),
		.valid_samples (valid_samples)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: errors");
		$finish;
	end

	// receiver: changing stall patterns, one long hold-off to back up the input
	initial begin
		forever begin
			@(posedge clk);
			if (!rx_held && words_checked >= 120) begin
				rx_held = 1'b1;
				rx_hold = 300;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_left = $urandom_range(5, 60);
				end
				rx_left--;
				case (rx_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	function automatic req_t mk(input bit st, input bit ab, input bit rd, input bit ec);
		req_t r;
		r.start = st;
		r.abrt = ab;
		r.rd = rd;
		r.echo = ec;
		return r;
	endfunction

	function automatic bit coin(input int one_in);
		return $urandom_range(0, one_in - 1) == 0;
	endfunction

	// offer one tick word, in bursts with gaps between them
	task automatic offer(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// stop offering and wait until every predicted word has left
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all four registers while the block is quiet
	task automatic set_config(input int t, input int mn, input int mx, input int to);
		int vals[4];
		vals[0] = t;
		vals[1] = mn;
		vals[2] = mx;
		vals[3] = to;
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= reg_idx_t'(i);
			cfg_wdata <= vals[i][TIME_W-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_trig = t;
		cur_min = mn;
		cur_max = mx;
		cur_timeout = to;
	endtask

	// one measurement: start, wait, echo pulse or abort or timeout, read
	task automatic measure_seq;
		int pre, tgt;
		offer(mk(1'b1, coin(2), coin(2), coin(6)));
		pre = $urandom_range(0, (cur_trig + 3 > 20) ? 20 : cur_trig + 3);
		if (coin(8) && cur_timeout <= 400)
			pre = cur_timeout + 2;
		for (int k = 0; k < pre; k++)
			offer(mk(coin(4), 1'b0, coin(4), 1'b0));
		if (coin(10)) begin
			offer(mk(coin(3), 1'b1, coin(3), coin(2)));
		end else begin
			case ($urandom_range(0, 6))
				0: tgt = cur_min - 1;
				1: tgt = cur_min;
				2: tgt = cur_min + 1;
				3: tgt = cur_max - 1;
				4: tgt = cur_max;
				5: tgt = cur_max + 1;
				default: tgt = $urandom_range(0, 60);
			endcase
			if (tgt < 0)
				tgt = 0;
			if (tgt > 60)
				tgt = $urandom_range(0, 60);
			// the captured width is one less than the high ticks
			for (int k = 0; k <= tgt; k++)
				offer(mk(coin(5), 1'b0, coin(5), 1'b1));
			offer(mk(coin(5), 1'b0, coin(5), 1'b0));
		end
		for (int k = $urandom_range(0, 3); k > 0; k--)
			offer(mk(coin(4), coin(4), 1'b0, coin(2)));
		offer(mk(coin(2), coin(2), 1'b1, coin(2)));
	endtask

	task automatic run_random(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if (coin(5)) begin
				for (int k = $urandom_range(1, 6); k > 0; k--)
					offer(req_t'(4'($urandom_range(0, 15))));
			end else begin
				measure_seq();
			end
		end
	endtask

	// stimulus
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, register reset values
		offer(mk(0, 0, 1, 0));  // read in idle is ignored
		offer(mk(0, 1, 0, 0));  // abort in idle is ignored
		offer(mk(1, 1, 1, 0));  // start wins over abort and read
		offer(mk(1, 0, 1, 0));  // start and read ignored while waiting
		offer(mk(0, 0, 0, 1));  // rising edge cuts the trigger pulse short
		repeat (5) offer(mk(0, 0, 0, 1));
		offer(mk(1, 0, 1, 0));  // falling edge, width below minimum
		offer(mk(1, 0, 0, 0));  // start in result ready is ignored
		offer(mk(1, 0, 1, 0));  // read taken, start ignored
		offer(mk(1, 0, 1, 1));  // read and start in idle: start taken
		offer(mk(0, 0, 0, 1));  // echo already high, no edge
		offer(mk(0, 1, 0, 1));  // abort while waiting for the rise
		offer(mk(0, 0, 1, 0));
		offer(mk(1, 0, 0, 0));
		offer(mk(0, 0, 0, 1));
		offer(mk(0, 1, 0, 0));  // abort beats a falling edge
		offer(mk(0, 0, 1, 0));

		// zero timeout ends the measurement on the next tick
		set_config(1, 6, 3, 0);
		offer(mk(1, 0, 0, 0));
		offer(mk(0, 0, 1, 0));
		offer(mk(0, 0, 1, 0));

		// random phases over a spread of settings
		set_config(1, 0, 65535, 65535);
		run_random(45);
		set_config(255, 3, 40, 120);
		run_random(45);
		set_config(4, 10, 20, 60);
		run_random(45);
		set_config(8, 65535, 0, 50);
		run_random(45);
		set_config(2, 5, 5, 1);
		run_random(45);
		set_config(6, 0, 0, 200);
		run_random(45);

		drain();
		$display("run: %0d tick words offered, %0d result words checked", items_sent,
			words_checked);
		$display("run: %0d measurements completed, %0d inside bounds", measurements,
			valid_samples);
		if (errors == 0 && pending == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
